@@ design/r6pq_pkg.sv @@
// ----------------------------------------------------------------------------
// r6pq_pkg
// Shared types, codes, field arithmetic and constant tables for the
// raid6 p/q syndrome and rebuild block.
// ----------------------------------------------------------------------------
package r6pq_pkg;

  // data disks at or beyond this index are ignored
  localparam int unsigned MAX_DISKS   = 16;
  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // field polynomial 0x11d: low byte and the carry-out bit
  localparam logic [7:0] GF_POLY_LOW = 8'h1d;
  localparam logic [7:0] GF_TOP_BIT  = 8'h80;
  // x^254 is the inverse of x in a field of 255 non-zero elements
  localparam int unsigned GF_ORDER   = 255;
  localparam int unsigned GF_INV_EXP = GF_ORDER - 1;

  // operating mode
  typedef enum logic [1:0] {
    MODE_GEN  = 2'd0,
    MODE_REC2 = 2'd1,
    MODE_RECP = 2'd2,
    MODE_RECQ = 2'd3
  } mode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_FAIL_A = 2'd1,
    REG_FAIL_B = 2'd2
  } reg_e;

  // classification of one beat
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_PAR_P = 2'd1,
    KIND_PAR_Q = 2'd2
  } item_kind_e;

  // configuration plus derived field coefficients
  typedef struct packed {
    mode_e      mode;
    logic [3:0] fail_a;
    logic [3:0] fail_b;
    logic [7:0] den;   // 1 / (2^a ^ 2^b)
    logic [7:0] pmul;  // 2^a / (2^a ^ 2^b)
    logic [7:0] ainv;  // 1 / 2^a
  } cfg_t;

  // classified beat as held in the queue
  typedef struct packed {
    item_kind_e kind;
    logic [7:0] value;   // parity byte, or p term of a data byte
    logic [7:0] q_term;  // weighted q term of a data byte
    logic       last;
    logic       stripe_end;
  } item_t;

  typedef logic [7:0] gf_tbl16_t  [16];
  typedef logic [7:0] gf_tbl256_t [256];

  // multiply by x with reduction
  function automatic logic [7:0] gf_xtime(input logic [7:0] a);
    logic [7:0] r;
    r = {a[6:0], 1'b0};
    if ((a & GF_TOP_BIT) != 8'h00) r = r ^ GF_POLY_LOW;
    return r;
  endfunction

  // general product in gf(2^8)
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] sh;
    acc = 8'h00;
    sh  = a;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) acc = acc ^ sh;
      sh = gf_xtime(sh);
    end
    return acc;
  endfunction

  // powers of two for every disk index
  function automatic gf_tbl16_t build_pow2();
    gf_tbl16_t  t;
    logic [7:0] v;
    v = 8'h01;
    for (int e = 0; e < 16; e++) begin
      t[e] = v;
      v    = gf_xtime(v);
    end
    return t;
  endfunction

  // inverse of every byte, zero maps to zero
  function automatic gf_tbl256_t build_recip();
    gf_tbl256_t t;
    logic [7:0] r;
    logic [7:0] base;
    logic [7:0] ex;
    for (int x = 0; x < 256; x++) begin
      r    = 8'h01;
      base = 8'(x);
      ex   = 8'(GF_INV_EXP);
      for (int k = 0; k < 8; k++) begin
        if (ex[k]) r = gf_mul(r, base);
        base = gf_mul(base, base);
      end
      t[x] = r;
    end
    return t;
  endfunction

  localparam gf_tbl16_t  POW2_TBL  = build_pow2();
  localparam gf_tbl256_t RECIP_TBL = build_recip();

endpackage

@@ design/r6pq_if.sv @@
// ----------------------------------------------------------------------------
// r6pq channel interfaces
// Valid/ready channels for disk beats, results and register writes.
// ----------------------------------------------------------------------------

// disk beat channel
interface r6pq_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] disk_index;
  logic [7:0] disk_byte;
  logic       last_disk;
  logic       stripe_end;

  modport source (output valid, disk_index, disk_byte, last_disk, stripe_end,
                  input ready);
  modport sink   (input valid, disk_index, disk_byte, last_disk, stripe_end,
                  output ready);
endinterface

// result channel
interface r6pq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic       column_last;

  modport source (output valid, first_byte, second_byte, column_last,
                  input ready);
  modport sink   (input valid, first_byte, second_byte, column_last,
                  output ready);
endinterface

// register write channel
interface r6pq_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/r6pq_cfg.sv @@
// ----------------------------------------------------------------------------
// r6pq_cfg
// Configuration registers and the field coefficients derived from them.
// ----------------------------------------------------------------------------
module r6pq_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  r6pq_cfg_if.sink           cfg_i,
  output r6pq_pkg::cfg_t     cfg_o
);
  import r6pq_pkg::*;

  mode_e      mode_q, mode_d;
  logic [3:0] fail_a_q, fail_a_d;
  logic [3:0] fail_b_q, fail_b_d;
  logic [7:0] den_q, den_d;
  logic [7:0] ainv_q, ainv_d;
  logic [7:0] pmul_q, pmul_d;
  logic       wr;

  // writes are always taken
  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid & cfg_i.ready;

  // register write decode
  always_comb begin
    mode_d   = mode_q;
    fail_a_d = fail_a_q;
    fail_b_d = fail_b_q;
    if (wr) begin
      unique case (reg_e'(cfg_i.index))
        REG_MODE:   mode_d   = mode_e'(cfg_i.data[1:0]);
        REG_FAIL_A: fail_a_d = cfg_i.data;
        REG_FAIL_B: fail_b_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  // coefficients, one table lookup or one product per stage
  always_comb begin
    den_d  = RECIP_TBL[POW2_TBL[fail_a_q] ^ POW2_TBL[fail_b_q]];
    ainv_d = RECIP_TBL[POW2_TBL[fail_a_q]];
    pmul_d = gf_mul(POW2_TBL[fail_a_q], den_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_GEN;
      fail_a_q <= 4'd2;
      fail_b_q <= 4'd3;
      den_q    <= 8'h00;
      ainv_q   <= 8'h00;
      pmul_q   <= 8'h00;
    end else begin
      mode_q   <= mode_d;
      fail_a_q <= fail_a_d;
      fail_b_q <= fail_b_d;
      den_q    <= den_d;
      ainv_q   <= ainv_d;
      pmul_q   <= pmul_d;
    end
  end

  assign cfg_o = '{mode: mode_q, fail_a: fail_a_q, fail_b: fail_b_q,
                   den: den_q, pmul: pmul_q, ainv: ainv_q};

endmodule

@@ design/r6pq_front.sv @@
// ----------------------------------------------------------------------------
// r6pq_front
// Accepts disk beats, sorts parity from data, drops failed or out of range
// data disks and forms the weighted q term.
// ----------------------------------------------------------------------------
module r6pq_front (
  r6pq_in_if.sink             in_i,
  input  r6pq_pkg::cfg_t      cfg_i,
  input  logic                full_i,
  output logic                push_o,
  output r6pq_pkg::item_t     item_o
);
  import r6pq_pkg::*;

  logic skip;
  logic in_range;

  assign in_i.ready = ~full_i;
  assign push_o     = in_i.valid & in_i.ready;

  // failed disks are left out of the sums
  always_comb begin
    skip = 1'b0;
    if (cfg_i.mode != MODE_GEN && in_i.disk_index == cfg_i.fail_a) skip = 1'b1;
    if (cfg_i.mode == MODE_REC2 && in_i.disk_index == cfg_i.fail_b) skip = 1'b1;
  end

  assign in_range = 32'(in_i.disk_index) < MAX_DISKS;

  // classify the beat
  always_comb begin
    item_o.last       = in_i.last_disk;
    item_o.stripe_end = in_i.stripe_end;
    item_o.value      = 8'h00;
    item_o.q_term     = 8'h00;
    priority if (in_i.disk_index == 4'd0) begin
      item_o.kind  = KIND_PAR_P;
      item_o.value = in_i.disk_byte;
    end else if (in_i.disk_index == 4'd1) begin
      item_o.kind  = KIND_PAR_Q;
      item_o.value = in_i.disk_byte;
    end else begin
      item_o.kind = KIND_DATA;
      if (in_range && !skip) begin
        item_o.value  = in_i.disk_byte;
        item_o.q_term = gf_mul(POW2_TBL[in_i.disk_index], in_i.disk_byte);
      end
    end
  end

endmodule

@@ design/r6pq_queue.sv @@
// ----------------------------------------------------------------------------
// r6pq_queue
// Small fifo of classified beats between front and back.
// ----------------------------------------------------------------------------
module r6pq_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  r6pq_pkg::item_t   item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output r6pq_pkg::item_t   item_o
);
  import r6pq_pkg::*;

  localparam logic [QUEUE_AW-1:0] LastPtr = QUEUE_AW'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_AW:0]   Full    = (QUEUE_AW + 1)'(QUEUE_DEPTH);

  item_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = count_q == Full;
  assign empty_o = count_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  // pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("queue fill level above depth");

  a_count_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
    else $error("queue fill level lost a push");

endmodule

@@ design/r6pq_back.sv @@
// ----------------------------------------------------------------------------
// r6pq_back
// Folds queued beats into the p and q sums, snapshots a column on its last
// beat and turns the snapshot into parity or rebuilt data bytes.
// ----------------------------------------------------------------------------
module r6pq_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  r6pq_pkg::cfg_t    cfg_i,
  input  logic              empty_i,
  input  r6pq_pkg::item_t   item_i,
  output logic              pop_o,
  r6pq_out_if.source        res_o
);
  import r6pq_pkg::*;

  logic [7:0] p_sum_q, p_sum_d;
  logic [7:0] q_sum_q, q_sum_d;
  logic [7:0] saved_p_q, saved_p_d;
  logic [7:0] saved_q_q, saved_q_d;

  logic       snap_valid_q, snap_valid_d;
  logic [7:0] snap_p_q, snap_q_q;
  logic       snap_end_q;

  logic       out_valid_q;
  logic [7:0] out_first_q, out_first_d;
  logic [7:0] out_second_q, out_second_d;
  logic       out_end_q;

  logic       out_free;
  logic       snap_free;
  logic       pop_last;
  logic [7:0] p_new, q_new;
  logic [7:0] qd;

  // stage handover
  assign out_free  = ~out_valid_q | res_o.ready;
  assign snap_free = ~snap_valid_q | out_free;
  assign pop_o     = ~empty_i & (~item_i.last | snap_free);
  assign pop_last  = pop_o & item_i.last;

  // fold one beat into the running state
  always_comb begin
    saved_p_d = saved_p_q;
    saved_q_d = saved_q_q;
    p_new     = p_sum_q;
    q_new     = q_sum_q;
    unique case (item_i.kind)
      KIND_PAR_P: saved_p_d = item_i.value;
      KIND_PAR_Q: saved_q_d = item_i.value;
      KIND_DATA: begin
        p_new = p_sum_q ^ item_i.value;
        q_new = q_sum_q ^ item_i.q_term;
      end
      default: ;
    endcase
    p_sum_d = item_i.last ? 8'h00 : p_new;
    q_sum_d = item_i.last ? 8'h00 : q_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_sum_q   <= 8'h00;
      q_sum_q   <= 8'h00;
      saved_p_q <= 8'h00;
      saved_q_q <= 8'h00;
    end else if (pop_o) begin
      p_sum_q   <= p_sum_d;
      q_sum_q   <= q_sum_d;
      saved_p_q <= saved_p_d;
      saved_q_q <= saved_q_d;
    end
  end

  // column snapshot: sums in generate mode, differences otherwise
  always_comb begin
    snap_valid_d = snap_valid_q;
    if (pop_last)                    snap_valid_d = 1'b1;
    else if (snap_valid_q && out_free) snap_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else begin
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_last) begin
      snap_p_q   <= (cfg_i.mode == MODE_GEN) ? p_new : (saved_p_d ^ p_new);
      snap_q_q   <= (cfg_i.mode == MODE_GEN) ? q_new : (saved_q_d ^ q_new);
      snap_end_q <= item_i.stripe_end;
    end
  end

  // result bytes from the snapshot
  assign qd = gf_mul(cfg_i.den, snap_q_q);

  always_comb begin
    out_first_d  = 8'h00;
    out_second_d = 8'h00;
    unique case (cfg_i.mode)
      MODE_GEN: begin
        out_first_d  = snap_p_q;
        out_second_d = snap_q_q;
      end
      MODE_REC2: begin
        out_second_d = gf_mul(cfg_i.pmul, snap_p_q) ^ qd;
        out_first_d  = out_second_d ^ snap_p_q;
      end
      MODE_RECP: out_first_d = snap_p_q;
      MODE_RECQ: out_first_d = gf_mul(cfg_i.ainv, snap_q_q);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= snap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && snap_valid_q) begin
      out_first_q  <= out_first_d;
      out_second_q <= out_second_d;
      out_end_q    <= snap_end_q;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.first_byte  = out_first_q;
  assign res_o.second_byte = out_second_q;
  assign res_o.column_last = out_end_q;

  a_sums_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_last |=> p_sum_q == 8'h00 && q_sum_q == 8'h00)
    else $error("sums not cleared after column end");

  a_snap_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_last |-> !snap_valid_q || out_free)
    else $error("column end popped over a held snapshot");

  a_out_from_snap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(snap_valid_q))
    else $error("result raised without a snapshot");

endmodule

@@ design/raid6_pq_syndrome_recover.sv @@
// ----------------------------------------------------------------------------
// raid6_pq_syndrome_recover
// RAID-6 P/Q syndrome generator and one- or two-disk data rebuilder in
// GF(2^8), one disk byte per beat.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   disk_index, disk_byte, last_disk, stripe_end
//   res_o    out  valid/ready   first_byte, second_byte, column_last
//   cfg_i    in   valid/ready   index (0 mode, 1 fail_a, 2 fail_b), data
//
// One beat is taken per cycle while the queue has room; the result of a column
// passes after its last beat through the queue, the snapshot stage and the
// output register. Register writes are always ready; the coefficients follow
// from them by a table lookup and then one field product. Reset clears the
// sums, the saved parity and all valid flags. A stalled result holds in the
// output register while up to four beats gather in the queue.
// ----------------------------------------------------------------------------
module raid6_pq_syndrome_recover (
  input  logic        clk_i,
  input  logic        rst_ni,
  r6pq_in_if.sink     in_i,
  r6pq_out_if.source  res_o,
  r6pq_cfg_if.sink    cfg_i
);
  import r6pq_pkg::*;

  cfg_t  cfg;
  item_t push_item;
  item_t head_item;
  logic  push;
  logic  full;
  logic  pop;
  logic  empty;

  // configuration
  r6pq_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // front: accept and classify
  r6pq_front u_front (
    .in_i   (in_i),
    .cfg_i  (cfg),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  // decoupling queue
  r6pq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (head_item)
  );

  // back: accumulate and produce results
  r6pq_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .empty_i (empty),
    .item_i  (head_item),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench for raid6_pq_syndrome_recover
// Streams disk beats column by column through the block under several mode
// and failed-disk settings and compares every result with a local p/q
// syndrome and rebuild predictor. Both channels idle at varying rates.
// ----------------------------------------------------------------------------
module testbench;
  import r6pq_pkg::*;

  localparam int NUM_PHASES     = 16;
  localparam int BEATS_PER_PHASE = 55;
  localparam int NUM_PLANNED    = 10;

  typedef struct {
    logic [3:0] disk_index;
    logic [7:0] disk_byte;
    logic       last_disk;
    logic       stripe_end;
  } disk_beat_t;

  typedef struct {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       column_last;
  } column_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  r6pq_in_if  disk_bus ();
  r6pq_out_if res_bus ();
  r6pq_cfg_if cfg_bus ();

  raid6_pq_syndrome_recover u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (disk_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  // beats waiting to be sent and columns waiting to come back
  disk_beat_t     pending_beats [$];
  column_result_t expected_columns [$];
  disk_beat_t     on_wire;
  column_result_t got_want;

  int beat_gap_pct     = 0;
  int result_stall_pct = 0;
  int fail_count       = 0;

  // predictor copy of the registers and the column state
  mode_e      cur_mode;
  logic [3:0] cur_fail_a;
  logic [3:0] cur_fail_b;
  logic [7:0] p_acc;
  logic [7:0] q_acc;
  logic [7:0] stored_p;
  logic [7:0] stored_q;

  // planned settings: each mode, failed disks reversed, equal and below two
  mode_e      plan_mode [NUM_PLANNED] = '{MODE_GEN, MODE_REC2, MODE_REC2, MODE_REC2,
                                          MODE_RECP, MODE_RECQ, MODE_REC2, MODE_RECQ,
                                          MODE_RECP, MODE_GEN};
  logic [3:0] plan_a [NUM_PLANNED]     = '{4'd2, 4'd2, 4'd15, 4'd7, 4'd15, 4'd2, 4'd1,
                                          4'd0, 4'd1, 4'd15};
  logic [3:0] plan_b [NUM_PLANNED]     = '{4'd3, 4'd15, 4'd2, 4'd7, 4'd0, 4'd3, 4'd0,
                                          4'd1, 4'd14, 4'd15};

  always #1 clk_i = ~clk_i;

  // field product, polynomial 0x11d
  function automatic logic [7:0] gf_product(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    logic [7:0] sh;
    acc = 8'h00;
    sh  = x;
    for (int n = 0; n < 8; n++) begin
      if (y[n]) acc = acc ^ sh;
      sh = {sh[6:0], 1'b0} ^ (sh[7] ? GF_POLY_LOW : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [7:0] gf_pow2(input logic [3:0] e);
    logic [7:0] v;
    v = 8'h01;
    for (int n = 0; n < int'(e); n++) v = gf_product(v, 8'h02);
    return v;
  endfunction

  // x^254, zero stays zero
  function automatic logic [7:0] gf_inverse(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] base;
    logic [7:0] ex;
    r    = 8'h01;
    base = x;
    ex   = 8'(GF_INV_EXP);
    for (int k = 0; k < 8; k++) begin
      if (ex[k]) r = gf_product(r, base);
      base = gf_product(base, base);
    end
    return r;
  endfunction

  // fold one beat into the column; returns 1 when a result is due
  function automatic bit absorb_beat(input disk_beat_t b, output column_result_t r);
    bit         skip;
    logic [7:0] ea;
    logic [7:0] eb;
    logic [7:0] den;
    logic [7:0] pd;
    logic [7:0] qd;
    r = '{8'h00, 8'h00, 1'b0};
    if (b.disk_index == 4'd0) begin
      stored_p = b.disk_byte;
    end else if (b.disk_index == 4'd1) begin
      stored_q = b.disk_byte;
    end else if (int'(b.disk_index) < int'(MAX_DISKS)) begin
      skip = (cur_mode != MODE_GEN && b.disk_index == cur_fail_a) ||
             (cur_mode == MODE_REC2 && b.disk_index == cur_fail_b);
      if (!skip) begin
        p_acc = p_acc ^ b.disk_byte;
        q_acc = q_acc ^ gf_product(gf_pow2(b.disk_index), b.disk_byte);
      end
    end
    if (!b.last_disk) return 1'b0;
    case (cur_mode)
      MODE_GEN: begin
        r.first_byte  = p_acc;
        r.second_byte = q_acc;
      end
      MODE_REC2: begin
        ea  = gf_pow2(cur_fail_a);
        eb  = gf_pow2(cur_fail_b);
        den = gf_inverse(ea ^ eb);
        pd  = stored_p ^ p_acc;
        qd  = gf_product(den, stored_q ^ q_acc);
        r.second_byte = gf_product(gf_product(ea, den), pd) ^ qd;
        r.first_byte  = r.second_byte ^ pd;
      end
      MODE_RECP: begin
        r.first_byte = stored_p ^ p_acc;
      end
      default: begin
        r.first_byte = gf_product(gf_inverse(gf_pow2(cur_fail_a)), stored_q ^ q_acc);
      end
    endcase
    r.column_last = b.stripe_end;
    p_acc = 8'h00;
    q_acc = 8'h00;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void push_beat(input int idx, input logic [7:0] val,
                                    input bit last, input bit send);
    disk_beat_t b;
    b.disk_index = 4'(idx);
    b.disk_byte  = val;
    b.last_disk  = last;
    b.stripe_end = send;
    pending_beats.push_back(b);
  endfunction

  // one column: parity then data disks in order, or a broken run of noise
  function automatic void queue_column();
    int  top;
    int  len;
    bit  keep_failed;
    bit  q_first;
    if ($urandom_range(99) < 15) begin
      len = $urandom_range(1, 6);
      for (int n = 0; n < len; n++)
        push_beat($urandom_range(15), pick_byte(), $urandom_range(99) < 20,
                  $urandom_range(1));
      return;
    end
    top         = ($urandom_range(99) < 70) ? $urandom_range(2, 7) : $urandom_range(8, 15);
    keep_failed = $urandom_range(1);
    q_first     = $urandom_range(1);
    if (q_first) push_beat(1, pick_byte(), 1'b0, $urandom_range(1));
    push_beat(0, pick_byte(), 1'b0, $urandom_range(1));
    if (!q_first) push_beat(1, pick_byte(), 1'b0, $urandom_range(1));
    for (int d = 2; d <= top; d++) begin
      if (keep_failed || d == top ||
          !(4'(d) == cur_fail_a || 4'(d) == cur_fail_b))
        push_beat(d, pick_byte(), d == top, ($urandom_range(99) < 25));
    end
  endfunction

  // register write, applied to the predictor on acceptance
  task automatic write_reg(input reg_e idx, input logic [3:0] val);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_MODE:   cur_mode   = mode_e'(val[1:0]);
      REG_FAIL_A: cur_fail_a = val;
      default:    cur_fail_b = val;
    endcase
  endtask

  // all beats sent, all results back, then room for the pipeline to settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || disk_bus.valid || expected_columns.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // beat driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      disk_bus.valid <= 1'b0;
    end else begin
      if (disk_bus.valid && disk_bus.ready) begin
        if (absorb_beat(on_wire, got_want)) expected_columns.push_back(got_want);
      end
      if (!disk_bus.valid || disk_bus.ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= beat_gap_pct) begin
          on_wire = pending_beats.pop_front();
          disk_bus.valid      <= 1'b1;
          disk_bus.disk_index <= on_wire.disk_index;
          disk_bus.disk_byte  <= on_wire.disk_byte;
          disk_bus.last_disk  <= on_wire.last_disk;
          disk_bus.stripe_end <= on_wire.stripe_end;
        end else begin
          disk_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i) begin : result_check
    column_result_t want;
    if (!rst_ni) begin
      res_bus.ready <= 1'b1;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (expected_columns.size() == 0) begin
          $error("result beat with nothing expected: %02h %02h %0b", res_bus.first_byte,
                 res_bus.second_byte, res_bus.column_last);
          fail_count++;
        end else begin
          want = expected_columns.pop_front();
          if (res_bus.first_byte !== want.first_byte) begin
            $error("first_byte: expected %02h, got %02h", want.first_byte,
                   res_bus.first_byte);
            fail_count++;
          end
          if (res_bus.second_byte !== want.second_byte) begin
            $error("second_byte: expected %02h, got %02h", want.second_byte,
                   res_bus.second_byte);
            fail_count++;
          end
          if (res_bus.column_last !== want.column_last) begin
            $error("column_last: expected %0b, got %0b", want.column_last,
                   res_bus.column_last);
            fail_count++;
          end
        end
      end
      res_bus.ready <= ($urandom_range(99) >= result_stall_pct);
    end
  end

  // stimulus: reset, then phases of settings and columns
  initial begin
    logic [3:0] fa;
    logic [3:0] fb;
    mode_e      md;
    rst_ni              = 1'b0;
    disk_bus.valid      = 1'b0;
    disk_bus.disk_index = 4'd0;
    disk_bus.disk_byte  = 8'h00;
    disk_bus.last_disk  = 1'b0;
    disk_bus.stripe_end = 1'b0;
    res_bus.ready       = 1'b1;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = REG_MODE;
    cfg_bus.data        = 4'd0;
    cur_mode   = MODE_GEN;
    cur_fail_a = 4'd2;
    cur_fail_b = 4'd3;
    p_acc      = 8'h00;
    q_acc      = 8'h00;
    stored_p   = 8'h00;
    stored_q   = 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < NUM_PLANNED) begin
        md = plan_mode[ph];
        fa = plan_a[ph];
        fb = plan_b[ph];
      end else begin
        md = mode_e'($urandom_range(3));
        fa = ($urandom_range(99) < 85) ? 4'($urandom_range(2, 15)) : 4'($urandom_range(1));
        fb = ($urandom_range(99) < 85) ? 4'($urandom_range(2, 15)) : 4'($urandom_range(1));
      end
      write_reg(REG_MODE, 4'(md));
      write_reg(REG_FAIL_A, fa);
      write_reg(REG_FAIL_B, fb);
      // wait for the new coefficients to settle
      repeat (4) @(posedge clk_i);
      @(negedge clk_i);

      case (ph % 4)
        0: begin beat_gap_pct = 0;  result_stall_pct = 0;  end
        1: begin beat_gap_pct = 71; result_stall_pct = 0;  end
        2: begin beat_gap_pct = 0;  result_stall_pct = 71; end
        default: begin beat_gap_pct = 23; result_stall_pct = 23; end
      endcase

      if (ph == 0) begin
        // full column with extreme bytes on every data disk
        push_beat(0, 8'hff, 1'b0, 1'b0);
        push_beat(1, 8'h00, 1'b0, 1'b1);
        for (int d = 2; d < 16; d++)
          push_beat(d, (d % 4 == 0) ? 8'hff : (d % 4 == 1) ? 8'h00 :
                       (d % 4 == 2) ? 8'h80 : 8'h01, d == 15, 1'b1);
        // repeated parity in one column
        push_beat(0, 8'h5a, 1'b0, 1'b0);
        push_beat(0, 8'ha5, 1'b0, 1'b0);
        push_beat(1, 8'hff, 1'b0, 1'b0);
        push_beat(2, 8'hff, 1'b1, 1'b0);
        // column closed on a parity byte
        push_beat(1, 8'h7f, 1'b1, 1'b1);
      end
      while (pending_beats.size() < BEATS_PER_PHASE) queue_column();
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[raid6_pq_syndrome_recover] OK");
    end else begin
      $display("[raid6_pq_syndrome_recover] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("[raid6_pq_syndrome_recover] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
design/r6pq_pkg.sv
design/r6pq_if.sv
design/r6pq_cfg.sv
design/r6pq_front.sv
design/r6pq_queue.sv
design/r6pq_back.sv
design/raid6_pq_syndrome_recover.sv
test/testbench.sv
